FILE: hw/rtl/plcs_pkg.sv
// ----------------------------------------------------------------------------
// plcs_pkg: shared types and constants of the contrast stretch
// Holds the register indexes, segment codes and the structures that travel
// between the front end, the divider and the output stage.
// ----------------------------------------------------------------------------
package plcs_pkg;

  localparam int PixW = 8;
  localparam int MagW = 2 * PixW;
  localparam int RemW = MagW + 2;
  localparam int DivW = PixW + 1;

  localparam logic [PixW-1:0] FULL_SCALE = 8'd255;

  localparam logic [1:0] REG_IN_LOW_KNEE   = 2'd0;
  localparam logic [1:0] REG_IN_HIGH_KNEE  = 2'd1;
  localparam logic [1:0] REG_OUT_LOW_KNEE  = 2'd2;
  localparam logic [1:0] REG_OUT_HIGH_KNEE = 2'd3;

  localparam logic [1:0] SEG_LOW  = 2'd0;
  localparam logic [1:0] SEG_MID  = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;

  typedef struct packed {
    logic [PixW-1:0] in_low;
    logic [PixW-1:0] in_high;
    logic [PixW-1:0] out_low;
    logic [PixW-1:0] out_high;
  } knees_t;

  typedef struct packed {
    logic [PixW-1:0] base;
    logic            neg;
    logic            zero;
    logic [1:0]      seg;
  } side_t;

endpackage

FILE: hw/rtl/plcs_front.sv
// ----------------------------------------------------------------------------
// plcs_front: segment selection and product
// Chooses the segment of each pixel, registers the operands, then forms the
// numerator magnitude in a second register stage.
// ----------------------------------------------------------------------------
module plcs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_in,
  input  logic [plcs_pkg::PixW-1:0] pixel,
  input  plcs_pkg::knees_t         knees,
  output logic                     vld_out,
  output logic [plcs_pkg::MagW-1:0] mag,
  output logic [plcs_pkg::PixW-1:0] den,
  output plcs_pkg::side_t          side
);

  logic [plcs_pkg::PixW-1:0] opa_nxt, opb_nxt, den_nxt;
  plcs_pkg::side_t           side_nxt;

  logic [plcs_pkg::PixW-1:0] opa_r, opb_r, den_a_r;
  plcs_pkg::side_t           side_a_r;
  logic                      vld_a_r;

  logic [plcs_pkg::MagW-1:0] mag_r;
  logic [plcs_pkg::PixW-1:0] den_b_r;
  plcs_pkg::side_t           side_b_r;
  logic                      vld_b_r;

  always_comb begin
    side_nxt.neg = 1'b0;
    if (pixel < knees.in_low) begin
      opa_nxt       = knees.out_low;
      opb_nxt       = pixel;
      den_nxt       = knees.in_low;
      side_nxt.base = '0;
      side_nxt.seg  = plcs_pkg::SEG_LOW;
    end else if (pixel > knees.in_high) begin
      opa_nxt       = plcs_pkg::FULL_SCALE - knees.out_high;
      opb_nxt       = pixel - knees.in_high;
      den_nxt       = plcs_pkg::FULL_SCALE - knees.in_high;
      side_nxt.base = knees.out_high;
      side_nxt.seg  = plcs_pkg::SEG_HIGH;
    end else begin
      if (knees.out_high < knees.out_low) begin
        opa_nxt      = knees.out_low - knees.out_high;
        side_nxt.neg = 1'b1;
      end else begin
        opa_nxt = knees.out_high - knees.out_low;
      end
      opb_nxt       = pixel - knees.in_low;
      den_nxt       = knees.in_high - knees.in_low;
      side_nxt.base = knees.out_low;
      side_nxt.seg  = plcs_pkg::SEG_MID;
    end
    side_nxt.zero = (den_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    den_a_r  <= den_nxt;
    side_a_r <= side_nxt;
    mag_r    <= opa_r * opb_r;
    den_b_r  <= den_a_r;
    side_b_r <= side_a_r;
  end

  assign vld_out = vld_b_r;
  assign mag     = mag_r;
  assign den     = den_b_r;
  assign side    = side_b_r;

endmodule

FILE: hw/rtl/plcs_div.sv
// ----------------------------------------------------------------------------
// plcs_div: pipelined rounding divider
// Restoring division of (2*mag + den) by 2*den, two quotient bits per
// stage over four stages, giving the quotient rounded half away from zero.
// ----------------------------------------------------------------------------
module plcs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_in,
  input  logic [plcs_pkg::MagW-1:0] mag,
  input  logic [plcs_pkg::PixW-1:0] den,
  input  plcs_pkg::side_t           side_in,
  output logic                      vld_out,
  output logic [plcs_pkg::PixW-1:0] quo,
  output plcs_pkg::side_t           side_out
);

  localparam int Stages = plcs_pkg::PixW / 2;

  logic [plcs_pkg::RemW-1:0] rem_r  [Stages-1];
  logic [plcs_pkg::DivW-1:0] dv_r   [Stages-1];
  logic [plcs_pkg::PixW-1:0] quo_r  [Stages];
  plcs_pkg::side_t           side_r [Stages];
  logic                      vld_r  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int Hi = plcs_pkg::PixW - 1 - 2 * k;
    localparam int Lo = Hi - 1;

    logic [plcs_pkg::RemW-1:0] rem_cur, rem_mid, rem_nxt, sub_hi, sub_lo;
    logic [plcs_pkg::DivW-1:0] dv_cur;
    logic [plcs_pkg::PixW-1:0] quo_cur, quo_nxt;
    plcs_pkg::side_t           side_cur;
    logic                      vld_cur;

    if (k == 0) begin : g_first
      assign rem_cur  = {1'b0, mag, 1'b0} + plcs_pkg::RemW'(den);
      assign dv_cur   = {den, 1'b0};
      assign quo_cur  = '0;
      assign side_cur = side_in;
      assign vld_cur  = vld_in;
    end else begin : g_next
      assign rem_cur  = rem_r[k-1];
      assign dv_cur   = dv_r[k-1];
      assign quo_cur  = quo_r[k-1];
      assign side_cur = side_r[k-1];
      assign vld_cur  = vld_r[k-1];
    end

    always_comb begin
      quo_nxt = quo_cur;
      sub_hi  = plcs_pkg::RemW'(dv_cur) << Hi;
      sub_lo  = plcs_pkg::RemW'(dv_cur) << Lo;
      rem_mid = rem_cur;
      if (rem_cur >= sub_hi) begin
        rem_mid     = rem_cur - sub_hi;
        quo_nxt[Hi] = 1'b1;
      end
      rem_nxt = rem_mid;
      if (rem_mid >= sub_lo) begin
        rem_nxt     = rem_mid - sub_lo;
        quo_nxt[Lo] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      quo_r[k]  <= quo_nxt;
      side_r[k] <= side_cur;
    end

    if (k < Stages - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        dv_r[k]  <= dv_cur;
      end
    end
  end

  assign vld_out  = vld_r[Stages-1];
  assign quo      = quo_r[Stages-1];
  assign side_out = side_r[Stages-1];

endmodule

FILE: hw/rtl/piecewise_linear_contrast_stretch.sv
// ----------------------------------------------------------------------------
// piecewise_linear_contrast_stretch: three-segment grey level mapping
// Maps each 8-bit pixel through the curve (0,0), knees, (255,255).
//
// A pixel is taken at a rising edge with start high and busy low. Busy is
// always low, so a new pixel may be offered in every cycle and the block
// sustains one transfer per clock.
// The result appears on out_pixel_out and out_segment with out_valid high
// for one cycle. Results leave in input order. Each pixel passes through
// the operand stage, the multiplier stage, four divider stages of two
// quotient bits each and the output register.
// The receiver cannot hold results off; every strobe is a transfer.
// The four knee registers are written through cfg_we, cfg_index and
// cfg_data, and should only be changed while no pixel is in flight.
// Reset clears the pipeline and sets the knees to the identity curve.
// ----------------------------------------------------------------------------
module piecewise_linear_contrast_stretch (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [plcs_pkg::PixW-1:0] in_pixel_in,
  output logic                      out_valid,
  output logic [plcs_pkg::PixW-1:0] out_pixel_out,
  output logic [1:0]                out_segment,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [plcs_pkg::PixW-1:0] cfg_data
);

  plcs_pkg::knees_t          knees_r;
  logic                      front_vld, div_vld;
  logic [plcs_pkg::MagW-1:0] front_mag;
  logic [plcs_pkg::PixW-1:0] front_den, div_quo;
  plcs_pkg::side_t           front_side, div_side;

  logic [plcs_pkg::PixW+1:0] level;
  logic [plcs_pkg::PixW-1:0] quo_eff, pixel_nxt;
  logic                      valid_r;
  logic [plcs_pkg::PixW-1:0] pixel_r;
  logic [1:0]                seg_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knees_r.in_low   <= '0;
      knees_r.in_high  <= plcs_pkg::FULL_SCALE;
      knees_r.out_low  <= '0;
      knees_r.out_high <= plcs_pkg::FULL_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        plcs_pkg::REG_IN_LOW_KNEE:   knees_r.in_low   <= cfg_data;
        plcs_pkg::REG_IN_HIGH_KNEE:  knees_r.in_high  <= cfg_data;
        plcs_pkg::REG_OUT_LOW_KNEE:  knees_r.out_low  <= cfg_data;
        plcs_pkg::REG_OUT_HIGH_KNEE: knees_r.out_high <= cfg_data;
        default: ;
      endcase
    end
  end

  plcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (start & ~busy),
    .pixel   (in_pixel_in),
    .knees   (knees_r),
    .vld_out (front_vld),
    .mag     (front_mag),
    .den     (front_den),
    .side    (front_side)
  );

  plcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (front_vld),
    .mag      (front_mag),
    .den      (front_den),
    .side_in  (front_side),
    .vld_out  (div_vld),
    .quo      (div_quo),
    .side_out (div_side)
  );

  // A zero divisor gives a zero quotient, so the level is the base alone.
  always_comb begin
    quo_eff = div_side.zero ? '0 : div_quo;
    if (div_side.neg) begin
      level = {2'b00, div_side.base} - {2'b00, quo_eff};
    end else begin
      level = {2'b00, div_side.base} + {2'b00, quo_eff};
    end
    if (level[plcs_pkg::PixW+1]) begin
      pixel_nxt = '0;
    end else if (level[plcs_pkg::PixW]) begin
      pixel_nxt = plcs_pkg::FULL_SCALE;
    end else begin
      pixel_nxt = level[plcs_pkg::PixW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
    seg_r   <= div_side.seg;
  end

  assign out_valid     = valid_r;
  assign out_pixel_out = pixel_r;
  assign out_segment   = seg_r;

endmodule
